FILE: rtl/fcbg_pkg.sv
// fcbg_pkg: constants shared by the fletcher check byte generator
// no dependencies; imported by the interfaces, the core, the modulo-255 folder and the checker
`timescale 1ns / 1ps

package fcbg_pkg;

	localparam int unsigned MOD_FLETCHER = 255;
	localparam logic [7:0] MOD_BYTE = 8'(MOD_FLETCHER);
	localparam logic [15:0] LOW_BYTE_MASK = 16'h00ff;
	localparam logic [15:0] CHECK_POS_RESET = 16'd14;

	typedef logic [7:0] byte_t;
	typedef logic [15:0] check_t;

endpackage

FILE: rtl/fcbg_in_if.sv
// fcbg_in_if: frame byte channel, valid/ready with data byte and last flag
// depends on fcbg_pkg
`timescale 1ns / 1ps

interface fcbg_in_if
	import fcbg_pkg::*;
;
	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

FILE: rtl/fcbg_out_if.sv
// fcbg_out_if: check value channel, valid/ready with the 16-bit check word
// depends on fcbg_pkg
`timescale 1ns / 1ps

interface fcbg_out_if
	import fcbg_pkg::*;
;
	logic   valid;
	logic   ready;
	check_t check_value;

	modport source (output valid, output check_value, input ready);
	modport sink (input valid, input check_value, output ready);
endinterface

FILE: rtl/fcbg_mod255.sv
// fcbg_mod255: combinational remainder of an unsigned word by 255
// folds byte chunks (2^8 = 1 mod 255); depends on fcbg_pkg
`timescale 1ns / 1ps

module fcbg_mod255
	import fcbg_pkg::*;
#(
	parameter int W = 32
) (
	input  logic [W-1:0] val,
	output byte_t        rem
);
	localparam int NCH = (W + 7) / 8;
	localparam int SUM_W = $clog2(NCH * 255 + 1);

	logic [NCH*8-1:0] padded;
	logic [SUM_W-1:0] chunk_sum;
	logic [8:0]       fold1;
	logic [8:0]       fold2;

	assign padded = (NCH*8)'(val);

	always_comb begin
		chunk_sum = '0;
		for (int i = 0; i < NCH; i++) begin
			chunk_sum = chunk_sum + SUM_W'(padded[i*8 +: 8]);
		end
	end

	generate
		if (SUM_W > 8) begin : g_fold
			assign fold1 = 9'(chunk_sum[7:0]) + 9'(chunk_sum[SUM_W-1:8]);
		end else begin : g_nofold
			assign fold1 = 9'(chunk_sum);
		end
	endgenerate

	assign fold2 = 9'(fold1[7:0]) + 9'(fold1[8]);
	assign rem = (fold2 >= 9'(MOD_BYTE)) ? 8'(fold2 - 9'(MOD_BYTE)) : fold2[7:0];
endmodule

FILE: rtl/fletcher_check_byte_generator_core.sv
// fletcher_check_byte_generator_core: ospf lsa fletcher checksum generator
// depends on fcbg_pkg, fcbg_in_if, fcbg_out_if, fcbg_mod255
// channel | dir | handshake     | payload
// frame   | in  | valid & ready | data_byte[7:0], last_byte
// result  | out | valid & ready | check_value[15:0] (x in 15:8, y in 7:0)
// cfg     | in  | cfg_wr_en     | cfg_wr_data[15:0] = checksum_position
// one byte per cycle while frame.ready is high; running sums update in the accept cycle
// a last byte accepted passes 5 registers (s1, s2, s3, s4, output) before it shows on result.valid
// a full register stage holds while the next is full and held, so stalls back up to frame.ready
// arst_n clears the sums, the index, the stage valids and sets checksum_position to 14
`timescale 1ns / 1ps

module fletcher_check_byte_generator_core
	import fcbg_pkg::*;
#(
	parameter int LENGTH_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data,
	fcbg_in_if.sink       frame,
	fcbg_out_if.source    result
);
	localparam int NW = LENGTH_BITS + 1;
	localparam int CMP_W = (LENGTH_BITS > 16 ? LENGTH_BITS : 16) + 1;
	localparam int D_W = (NW > 16 ? NW : 16) + 1;
	localparam int M_W = D_W + 9;
	localparam int X_W = M_W + 2;

	logic [15:0]            pos_q;
	byte_t                  sum_a_q;
	byte_t                  sum_b_q;
	logic [LENGTH_BITS-1:0] idx_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4, out_v_q;
	logic en1, en2, en3, en4, en_out;
	logic accept;

	byte_t                 a_s1, b_s1, a_s2, b_s2;
	logic signed [D_W-1:0] d_s1;
	logic signed [M_W-1:0] m_s2;
	logic signed [X_W-1:0] x_s3, y_s3;
	logic [X_W-1:0]        mag_x_s4, mag_y_s4;
	logic                  neg_x_s4, neg_y_s4;
	check_t                check_q;

	// byte update
	logic                  pos_hit;
	byte_t                 din;
	logic [8:0]            sa_sum, sb_sum;
	byte_t                 na, nb;
	logic [NW-1:0]         n_len;
	logic signed [D_W-1:0] d_c;

	logic signed [M_W-1:0] m_c;
	logic signed [X_W-1:0] x_c, y_c;
	logic [X_W-1:0]        mag_x_c, mag_y_c;
	byte_t                 rem_x, rem_y, byte_x, byte_y;

	assign en_out = !out_v_q || result.ready;
	assign en4 = !v4_s4 || en_out;
	assign en3 = !v3_s3 || en4;
	assign en2 = !v2_s2 || en3;
	assign en1 = !v1_s1 || en2;
	assign frame.ready = en1;
	assign accept = frame.valid && en1;

	assign pos_hit = (CMP_W'(idx_q) == CMP_W'(pos_q)) ||
		(CMP_W'(idx_q) == CMP_W'(pos_q) + CMP_W'(1));
	assign din = pos_hit ? '0 : frame.data_byte;
	assign sa_sum = 9'(sum_a_q) + 9'(din);
	assign na = (sa_sum >= 9'(MOD_BYTE)) ? 8'(sa_sum - 9'(MOD_BYTE)) : sa_sum[7:0];
	assign sb_sum = 9'(sum_b_q) + 9'(na);
	assign nb = (sb_sum >= 9'(MOD_BYTE)) ? 8'(sb_sum - 9'(MOD_BYTE)) : sb_sum[7:0];
	assign n_len = NW'(idx_q) + NW'(1);
	assign d_c = $signed(D_W'(n_len)) - $signed(D_W'(pos_q));

	assign m_c = d_s1 * $signed({1'b0, a_s1});
	assign x_c = X_W'(m_s2 - $signed({1'b0, b_s2}) - $signed({1'b0, a_s2}));
	assign y_c = X_W'($signed({1'b0, b_s2}) - m_s2 - 1);

	// negative x is decremented, nonnegative y incremented, before the remainder
	assign mag_x_c = x_s3[X_W-1] ? X_W'(-x_s3 + 1) : X_W'(x_s3);
	assign mag_y_c = y_s3[X_W-1] ? X_W'(-y_s3) : X_W'(y_s3 + 1);

	fcbg_mod255 #(.W(X_W)) u_mod_x (.val(mag_x_s4), .rem(rem_x));
	fcbg_mod255 #(.W(X_W)) u_mod_y (.val(mag_y_s4), .rem(rem_y));

	assign byte_x = (rem_x == '0) ? MOD_BYTE : (neg_x_s4 ? 8'(8'd0 - rem_x) : rem_x);
	assign byte_y = (rem_y == '0) ? MOD_BYTE : (neg_y_s4 ? 8'(8'd0 - rem_y) : rem_y);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= CHECK_POS_RESET;
		end else if (cfg_wr_en) begin
			pos_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_a_q <= '0;
			sum_b_q <= '0;
			idx_q   <= '0;
		end else if (accept) begin
			if (frame.last_byte) begin
				sum_a_q <= '0;
				sum_b_q <= '0;
				idx_q   <= '0;
			end else begin
				sum_a_q <= na;
				sum_b_q <= nb;
				idx_q   <= idx_q + LENGTH_BITS'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1   <= 1'b0;
			v2_s2   <= 1'b0;
			v3_s3   <= 1'b0;
			v4_s4   <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (en1) v1_s1 <= accept && frame.last_byte;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (en_out) out_v_q <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			a_s1 <= na;
			b_s1 <= nb;
			d_s1 <= d_c;
		end
		if (en2) begin
			a_s2 <= a_s1;
			b_s2 <= b_s1;
			m_s2 <= m_c;
		end
		if (en3) begin
			x_s3 <= x_c;
			y_s3 <= y_c;
		end
		if (en4) begin
			mag_x_s4 <= mag_x_c;
			mag_y_s4 <= mag_y_c;
			neg_x_s4 <= x_s3[X_W-1];
			neg_y_s4 <= y_s3[X_W-1];
		end
		if (en_out) begin
			check_q <= ({byte_x, 8'h00} | (16'(byte_y) & LOW_BYTE_MASK));
		end
	end

	assign result.valid = out_v_q;
	assign result.check_value = check_q;
endmodule

FILE: rtl/fcbg_check.sv
// fcbg_check: port-level assertions for the fletcher check byte generator
// bound to fletcher_check_byte_generator_core; depends on fcbg_pkg
`timescale 1ns / 1ps

module fcbg_check
	import fcbg_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	input logic   in_valid,
	input logic   in_ready,
	input logic   in_last,
	input logic   out_valid,
	input logic   out_ready,
	input check_t check_value
);
	logic [2:0] pending_q;
	logic       last_in;
	logic       word_out;

	assign last_in = in_valid && in_ready && in_last;
	assign word_out = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else begin
			pending_q <= pending_q + 3'(last_in) - 3'(word_out);
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped before it was taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(check_value))
		else $error("stalled check word changed");

	a_no_invented: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pending_q != 3'd0)
		else $error("result word without a pending last byte");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pending_q <= 3'd5)
		else $error("more frames in flight than pipeline stages");

	a_no_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (check_value[15:8] != 8'd0) && (check_value[7:0] != 8'd0))
		else $error("check byte of zero");
endmodule

bind fletcher_check_byte_generator_core fcbg_check u_fcbg_check (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (frame.valid),
	.in_ready    (frame.ready),
	.in_last     (frame.last_byte),
	.out_valid   (result.valid),
	.out_ready   (result.ready),
	.check_value (result.check_value)
);
